FILE: rtl/lec_pkg.sv
// shared types, constants and the gamma table of the addressable led color encoder
// no dependencies; every other file uses these by scoped names
package lec_pkg;

   localparam int LED_COUNT   = 64;
   localparam int LED_ADDR_W  = $clog2(LED_COUNT);
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

   typedef enum logic [1:0] {
      ACT_SET_ONE   = 2'd0,
      ACT_SET_ALL   = 2'd1,
      ACT_CLEAR_ALL = 2'd2,
      ACT_FETCH     = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      CH_GREEN = 2'd0,
      CH_RED   = 2'd1,
      CH_BLUE  = 2'd2
   } channel_type;

   typedef enum logic [1:0] {
      CSR_BRIGHTNESS = 2'd0,
      CSR_CODE_ONE   = 2'd1,
      CSR_CODE_ZERO  = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_FILL  = 2'd1,
      OP_FETCH = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'd0,
      ST_SCALE = 2'd1,
      ST_EMIT  = 2'd2
   } back_state_type;

   typedef struct packed {
      logic [1:0]  action;
      logic [5:0]  led_index;
      logic [23:0] color;
   } req_type;

   typedef struct packed {
      logic [63:0] code_word;
      logic [1:0]  channel;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [7:0] brightness;
      logic [7:0] code_one;
      logic [7:0] code_zero;
   } cfg_type;

   typedef struct packed {
      op_type                op;
      logic [LED_ADDR_W-1:0] addr;
      logic [23:0]           color;
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   localparam logic [7:0] GAMMA_ROM [0:255] = '{
      8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
      8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
      8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
      8'd0,   8'd0,   8'd0,   8'd0,   8'd1,   8'd1,   8'd1,   8'd1,
      8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,
      8'd1,   8'd2,   8'd2,   8'd2,   8'd2,   8'd2,   8'd2,   8'd2,
      8'd2,   8'd3,   8'd3,   8'd3,   8'd3,   8'd3,   8'd3,   8'd3,
      8'd4,   8'd4,   8'd4,   8'd4,   8'd4,   8'd5,   8'd5,   8'd5,
      8'd5,   8'd6,   8'd6,   8'd6,   8'd6,   8'd7,   8'd7,   8'd7,
      8'd7,   8'd8,   8'd8,   8'd8,   8'd9,   8'd9,   8'd9,   8'd10,
      8'd10,  8'd10,  8'd11,  8'd11,  8'd11,  8'd12,  8'd12,  8'd13,
      8'd13,  8'd13,  8'd14,  8'd14,  8'd15,  8'd15,  8'd16,  8'd16,
      8'd17,  8'd17,  8'd18,  8'd18,  8'd19,  8'd19,  8'd20,  8'd20,
      8'd21,  8'd21,  8'd22,  8'd22,  8'd23,  8'd24,  8'd24,  8'd25,
      8'd25,  8'd26,  8'd27,  8'd27,  8'd28,  8'd29,  8'd29,  8'd30,
      8'd31,  8'd32,  8'd32,  8'd33,  8'd34,  8'd35,  8'd35,  8'd36,
      8'd37,  8'd38,  8'd39,  8'd39,  8'd40,  8'd41,  8'd42,  8'd43,
      8'd44,  8'd45,  8'd46,  8'd47,  8'd48,  8'd49,  8'd50,  8'd50,
      8'd51,  8'd52,  8'd54,  8'd55,  8'd56,  8'd57,  8'd58,  8'd59,
      8'd60,  8'd61,  8'd62,  8'd63,  8'd64,  8'd66,  8'd67,  8'd68,
      8'd69,  8'd70,  8'd72,  8'd73,  8'd74,  8'd75,  8'd77,  8'd78,
      8'd79,  8'd81,  8'd82,  8'd83,  8'd85,  8'd86,  8'd87,  8'd89,
      8'd90,  8'd92,  8'd93,  8'd95,  8'd96,  8'd98,  8'd99,  8'd101,
      8'd102, 8'd104, 8'd105, 8'd107, 8'd109, 8'd110, 8'd112, 8'd114,
      8'd115, 8'd117, 8'd119, 8'd120, 8'd122, 8'd124, 8'd126, 8'd127,
      8'd129, 8'd131, 8'd133, 8'd135, 8'd137, 8'd138, 8'd140, 8'd142,
      8'd144, 8'd146, 8'd148, 8'd150, 8'd152, 8'd154, 8'd156, 8'd158,
      8'd160, 8'd162, 8'd164, 8'd167, 8'd169, 8'd171, 8'd173, 8'd175,
      8'd177, 8'd180, 8'd182, 8'd184, 8'd186, 8'd189, 8'd191, 8'd193,
      8'd196, 8'd198, 8'd200, 8'd203, 8'd205, 8'd208, 8'd210, 8'd213,
      8'd215, 8'd218, 8'd220, 8'd223, 8'd225, 8'd228, 8'd231, 8'd233,
      8'd236, 8'd239, 8'd241, 8'd244, 8'd247, 8'd249, 8'd252, 8'd255
   };

endpackage

FILE: rtl/addressable_led_color_encoder.sv
// top level of the addressable led color encoder: csr registers, front end, queue, back end
// depends on lec_pkg, lec_front, lec_queue, lec_back
//
//   channel   direction  handshake          payload
//   req       in         req_valid/stall    action, led_index, color
//   rsp       out        rsp_valid/stall    code_word, channel, last
//   csr       in         csr_valid/ready    csr_index, csr_data
//
// a set, set all or clear is done by the back end from idle; a fetch runs through store read, first
// scale, then one word per cycle while rsp is not stalled, through the multiply and gamma stage
// set all and clear reset the per-led valid bits at once, so there is no clearing pass
// up to four requests wait in the queue while the back end is busy or rsp is stalled
// reset makes the store read as zero and loads brightness 255, code_one 248, code_zero 192
module addressable_led_color_encoder (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  lec_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output lec_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic [7:0]       csr_data
);

   lec_pkg::cfg_type cfg_ff, cfg_in;
   lec_pkg::cmd_type front_cmd, head_cmd;
   lec_pkg::queue_status_type q_status;
   logic push, pop;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            lec_pkg::CSR_BRIGHTNESS: cfg_in.brightness = csr_data;
            lec_pkg::CSR_CODE_ONE:   cfg_in.code_one   = csr_data;
            lec_pkg::CSR_CODE_ZERO:  cfg_in.code_zero  = csr_data;
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.brightness <= 8'd255;
         cfg_ff.code_one   <= 8'd248;
         cfg_ff.code_zero  <= 8'd192;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   lec_front u_front (
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req       (req_data),
      .q_status  (q_status),
      .push      (push),
      .cmd       (front_cmd)
   );

   lec_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (front_cmd),
      .pop       (pop),
      .head      (head_cmd),
      .status    (q_status)
   );

   lec_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd       (head_cmd),
      .q_status  (q_status),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp_data)
   );

   a_last_on_blue: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.last == (rsp_data.channel == lec_pkg::CH_BLUE)))
      else $error("last flag does not match blue channel");

   a_word_follows: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_data.last) |=>
      (rsp_valid && rsp_data.channel == $past(rsp_data.channel) + 2'd1))
      else $error("next channel word of a fetch did not follow");

   a_fetch_starts_green: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> (rsp_data.channel == lec_pkg::CH_GREEN))
      else $error("fetch output did not start with green");

endmodule

FILE: rtl/lec_front.sv
// front end: takes request transfers, drops out-of-range ones and turns the rest into commands
// depends on lec_pkg
module lec_front (
   input  logic                      req_valid,
   output logic                      req_stall,
   input  lec_pkg::req_type          req,
   input  lec_pkg::queue_status_type q_status,
   output logic                      push,
   output lec_pkg::cmd_type          cmd
);

   logic in_range;

   assign in_range  = 32'(req.led_index) < lec_pkg::LED_COUNT;
   assign req_stall = q_status.full;

   always_comb begin
      cmd.addr  = req.led_index[lec_pkg::LED_ADDR_W-1:0];
      cmd.color = req.color;
      cmd.op    = lec_pkg::OP_WRITE;
      push      = 1'b0;
      unique case (lec_pkg::action_type'(req.action))
         lec_pkg::ACT_SET_ONE: begin
            cmd.op = lec_pkg::OP_WRITE;
            push   = req_valid && !q_status.full && in_range;
         end
         lec_pkg::ACT_SET_ALL: begin
            cmd.op = lec_pkg::OP_FILL;
            push   = req_valid && !q_status.full;
         end
         lec_pkg::ACT_CLEAR_ALL: begin
            cmd.op    = lec_pkg::OP_FILL;
            cmd.color = 24'd0;
            push      = req_valid && !q_status.full;
         end
         lec_pkg::ACT_FETCH: begin
            cmd.op = lec_pkg::OP_FETCH;
            push   = req_valid && !q_status.full && in_range;
         end
         default: begin
            push = 1'b0;
         end
      endcase
   end

endmodule

FILE: rtl/lec_queue.sv
// short command queue between front end and back end
// depends on lec_pkg
module lec_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  lec_pkg::cmd_type          push_data,
   input  logic                      pop,
   output lec_pkg::cmd_type          head,
   output lec_pkg::queue_status_type status
);

   lec_pkg::cmd_type entry_ff [lec_pkg::QUEUE_DEPTH];
   logic [lec_pkg::QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [lec_pkg::QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [lec_pkg::QUEUE_PTR_W:0]   count_ff, count_in;
   logic do_push, do_pop;

   assign status.empty = count_ff == '0;
   assign status.full  = count_ff == (lec_pkg::QUEUE_PTR_W+1)'(lec_pkg::QUEUE_DEPTH);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head         = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == lec_pkg::QUEUE_PTR_W'(lec_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == lec_pkg::QUEUE_PTR_W'(lec_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: rtl/lec_back.sv
// back end: color store, brightness scaling, gamma lookup, bit expansion and result register
// depends on lec_pkg
module lec_back (
   input  logic                      clock,
   input  logic                      reset,
   input  lec_pkg::cfg_type          cfg,
   input  lec_pkg::cmd_type          cmd,
   input  lec_pkg::queue_status_type q_status,
   output logic                      pop,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output lec_pkg::rsp_type          rsp
);

   logic [23:0] mem [lec_pkg::LED_COUNT];
   logic [lec_pkg::LED_COUNT-1:0] valid_ff, valid_in;
   logic [23:0] fill_ff, fill_in;
   logic [23:0] rd_ff;
   logic        hit_ff;
   lec_pkg::back_state_type state_ff, state_in;
   lec_pkg::channel_type    chan_ff, chan_in, chan_next;
   logic [7:0]  scaled_ff, scaled_in;
   logic        rsp_valid_ff, rsp_valid_in;
   lec_pkg::rsp_type rsp_ff, rsp_in;
   logic        wr_en, rd_en, out_free;
   logic [23:0] col;

   function automatic logic [7:0] chan_byte(input logic [23:0] c,
                                            input lec_pkg::channel_type ch);
      logic [7:0] b;
      unique case (ch)
         lec_pkg::CH_GREEN: b = c[15:8];
         lec_pkg::CH_RED:   b = c[23:16];
         lec_pkg::CH_BLUE:  b = c[7:0];
         default:           b = 8'd0;
      endcase
      return b;
   endfunction

   function automatic logic [7:0] scale(input logic [7:0] c, input logic [7:0] b);
      logic [15:0] p;
      p = 16'(c) * 16'(b);
      return p[15:8];
   endfunction

   function automatic logic [63:0] expand(input logic [7:0] v, input logic [7:0] one,
                                          input logic [7:0] zero);
      logic [63:0] w;
      for (int i = 0; i < 8; i++) begin
         w[8*i +: 8] = v[i] ? one : zero;
      end
      return w;
   endfunction

   assign col       = hit_ff ? rd_ff : fill_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   always_comb begin
      unique case (chan_ff)
         lec_pkg::CH_GREEN: chan_next = lec_pkg::CH_RED;
         lec_pkg::CH_RED:   chan_next = lec_pkg::CH_BLUE;
         default:           chan_next = lec_pkg::CH_GREEN;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lec_pkg::ST_IDLE: begin
            if (!q_status.empty && cmd.op == lec_pkg::OP_FETCH) begin
               state_in = lec_pkg::ST_SCALE;
            end
         end
         lec_pkg::ST_SCALE: begin
            state_in = lec_pkg::ST_EMIT;
         end
         lec_pkg::ST_EMIT: begin
            if (out_free && chan_ff == lec_pkg::CH_BLUE) begin
               state_in = lec_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lec_pkg::ST_IDLE;
         end
      endcase
   end

   // outputs and datapath
   always_comb begin
      pop          = 1'b0;
      wr_en        = 1'b0;
      rd_en        = 1'b0;
      valid_in     = valid_ff;
      fill_in      = fill_ff;
      chan_in      = chan_ff;
      scaled_in    = scaled_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      unique case (state_ff)
         lec_pkg::ST_IDLE: begin
            if (!q_status.empty) begin
               pop = 1'b1;
               unique case (cmd.op)
                  lec_pkg::OP_WRITE: begin
                     wr_en               = 1'b1;
                     valid_in[cmd.addr]  = 1'b1;
                  end
                  lec_pkg::OP_FILL: begin
                     fill_in  = cmd.color;
                     valid_in = '0;
                  end
                  lec_pkg::OP_FETCH: begin
                     rd_en   = 1'b1;
                     chan_in = lec_pkg::CH_GREEN;
                  end
                  default: begin
                     pop = 1'b1;
                  end
               endcase
            end
         end
         lec_pkg::ST_SCALE: begin
            scaled_in = scale(chan_byte(col, chan_ff), cfg.brightness);
         end
         lec_pkg::ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in     = 1'b1;
               rsp_in.code_word = expand(lec_pkg::GAMMA_ROM[scaled_ff], cfg.code_one,
                                         cfg.code_zero);
               rsp_in.channel   = chan_ff;
               rsp_in.last      = chan_ff == lec_pkg::CH_BLUE;
               chan_in          = chan_next;
               scaled_in        = scale(chan_byte(col, chan_next), cfg.brightness);
            end
         end
         default: begin
            pop = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lec_pkg::ST_IDLE;
         valid_ff     <= '0;
         fill_ff      <= 24'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      chan_ff   <= chan_in;
      scaled_ff <= scaled_in;
      rsp_ff    <= rsp_in;
   end

   // color store
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[cmd.addr] <= cmd.color;
      end
      if (rd_en) begin
         rd_ff  <= mem[cmd.addr];
         hit_ff <= valid_ff[cmd.addr];
      end
   end

endmodule
